// ===== rtl/pwvm_pkg.sv =====
// ----------------------------------------------------------------------------
// pwvm_pkg: shared constants and types
// Sizes, operation codes, FSM states, the pitch multiplier table and the
// structs that pass between the sequencer, the memories and the multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pwvm_pkg;

  localparam int VOICE_COUNT = 15;
  localparam int WAVE_DEPTH  = 1024;             // power of two
  localparam int WAVE_AW     = $clog2(WAVE_DEPTH);
  localparam int FRAC_W      = 16;
  localparam int PH_W        = WAVE_AW + FRAC_W;
  localparam int STEP_W      = 26;
  localparam int SUM_W       = ((PH_W > STEP_W) ? PH_W : STEP_W) + 1;
  localparam int NOTE_COUNT  = 128;
  localparam int KEY_W       = $clog2(NOTE_COUNT);
  localparam int CHAN_W      = 4;
  localparam int VEL_W       = 7;
  localparam int BEND_W      = 14;
  localparam int WADDR_W     = 10;
  localparam int WAVE_W      = 16;
  localparam int FUNC_W      = 3;
  localparam int VI_W        = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  localparam int MULT_W      = 17;
  localparam int MUL_A_W     = STEP_W + 1;
  localparam int MUL_B_W     = MULT_W + 1;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;

  localparam int TERM_SHIFT  = 4;
  localparam int ACC_SHIFT   = 10;
  localparam int ACC_W       = WAVE_W + VEL_W - TERM_SHIFT + 2 + VI_W;

  localparam int DAC_W       = 12;
  localparam int DAC_MID     = 2048;
  localparam int DAC_MAX     = 4095;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK     = 3'd0,
    FUNC_NOTE_ON  = 3'd1,
    FUNC_NOTE_OFF = 3'd2,
    FUNC_BEND     = 3'd3,
    FUNC_WAVE_WR  = 3'd4,
    FUNC_STEP_WR  = 3'd5,
    FUNC_STOP     = 3'd6
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK_PH,
    ST_TICK_MUL,
    ST_TICK_ACC,
    ST_TICK_OUT,
    ST_ON_SCAN,
    ST_ON_LOAD,
    ST_OFF_SCAN,
    ST_OFF_LOAD,
    ST_BEND_SCAN,
    ST_BEND_MUL,
    ST_BEND_WR
  } state_e;

  // Q1.16 pitch multipliers, 0.943874 .. 1.057552
  localparam logic [MULT_W-1:0] BEND_MULT [64] = '{
    17'd61858, 17'd61970, 17'd62081, 17'd62194, 17'd62306, 17'd62419, 17'd62531, 17'd62644,
    17'd62757, 17'd62871, 17'd62984, 17'd63098, 17'd63212, 17'd63326, 17'd63441, 17'd63556,
    17'd63670, 17'd63785, 17'd63901, 17'd64016, 17'd64132, 17'd64248, 17'd64364, 17'd64480,
    17'd64596, 17'd64713, 17'd64830, 17'd64947, 17'd65065, 17'd65182, 17'd65300, 17'd65418,
    17'd65536, 17'd65654, 17'd65773, 17'd65892, 17'd66011, 17'd66130, 17'd66250, 17'd66369,
    17'd66489, 17'd66609, 17'd66730, 17'd66850, 17'd66971, 17'd67092, 17'd67213, 17'd67335,
    17'd67456, 17'd67578, 17'd67700, 17'd67823, 17'd67945, 17'd68068, 17'd68191, 17'd68314,
    17'd68438, 17'd68561, 17'd68685, 17'd68809, 17'd68933, 17'd69058, 17'd69183, 17'd69308
  };

  typedef struct packed {
    logic                     wave_we;
    logic [WAVE_AW-1:0]       wave_waddr;
    logic signed [WAVE_W-1:0] wave_wdata;
    logic [WAVE_AW-1:0]       wave_raddr;
    logic                     step_we;
    logic [KEY_W-1:0]         step_waddr;
    logic [STEP_W-1:0]        step_wdata;
    logic [KEY_W-1:0]         step_raddr;
  } mem_req_t;

  typedef struct packed {
    logic signed [WAVE_W-1:0] wave_rdata;
    logic [STEP_W-1:0]        step_rdata;
  } mem_rsp_t;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

`default_nettype wire

// ===== rtl/pwvm_mem.sv =====
// ----------------------------------------------------------------------------
// pwvm_mem: wave memory and note step table
// Single write port and single registered read port on each array.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwvm_mem
  import pwvm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire mem_req_t req_i,
  output mem_rsp_t      rsp_o
);

  logic signed [WAVE_W-1:0] wave_mem [WAVE_DEPTH];
  logic [STEP_W-1:0]        step_mem [NOTE_COUNT];

  always_ff @(posedge clk_i) begin
    if (req_i.wave_we) begin
      wave_mem[req_i.wave_waddr] <= req_i.wave_wdata;
    end
    if (req_i.step_we) begin
      step_mem[req_i.step_waddr] <= req_i.step_wdata;
    end
    rsp_o.wave_rdata <= wave_mem[req_i.wave_raddr];
    rsp_o.step_rdata <= step_mem[req_i.step_raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/pwvm_mul.sv =====
// ----------------------------------------------------------------------------
// pwvm_mul: shared signed multiplier
// One registered 27x18 product, used for voice gain and for pitch bend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwvm_mul
  import pwvm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire mul_req_t             req_i,
  output logic signed [PROD_W-1:0]  prod_o
);

  always_ff @(posedge clk_i) begin
    prod_o <= req_i.a * req_i.b;
  end

endmodule

`default_nettype wire

// ===== rtl/pwvm_ctrl.sv =====
// ----------------------------------------------------------------------------
// pwvm_ctrl: voice state and sequencer
// Holds the voice registers, walks the voices one at a time for tick,
// note on/off and bend, and drives the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwvm_ctrl
  import pwvm_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [FUNC_W-1:0]       func_i,
  input  wire logic [CHAN_W-1:0]       channel_i,
  input  wire logic [KEY_W-1:0]        key_i,
  input  wire logic [VEL_W-1:0]        velocity_i,
  input  wire logic [BEND_W-1:0]       bend_i,
  input  wire logic [WADDR_W-1:0]      wave_addr_i,
  input  wire logic signed [WAVE_W-1:0] wave_value_i,
  input  wire logic [STEP_W-1:0]       step_value_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [DAC_W-1:0]             dac_sample_o,
  output mem_req_t                     mem_req_o,
  input  wire mem_rsp_t                mem_rsp_i,
  output mul_req_t                     mul_req_o,
  input  wire logic signed [PROD_W-1:0] mul_prod_i
);

  state_e state_q, state_d;

  logic [VI_W-1:0]   vidx_q;
  logic [CHAN_W-1:0] chan_q;
  logic [KEY_W-1:0]  key_q;
  logic [VEL_W-1:0]  vel_q;
  logic [MULT_W-1:0] mult_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic              out_valid_q;
  logic [DAC_W-1:0]  dac_q;

  logic              voice_active_q  [VOICE_COUNT];
  logic [KEY_W-1:0]  voice_note_q    [VOICE_COUNT];
  logic [CHAN_W-1:0] voice_channel_q [VOICE_COUNT];
  logic [VEL_W-1:0]  voice_volume_q  [VOICE_COUNT];
  logic [STEP_W-1:0] voice_step_q    [VOICE_COUNT];
  logic [PH_W-1:0]   voice_phase_q   [VOICE_COUNT];

  logic accept, is_last, out_free;
  logic cur_active, off_hit, bend_hit;
  logic vidx_inc, vw_stop, vw_phase, vw_on, vw_off, vw_bend, out_load;
  logic [SUM_W-1:0]  phase_sum;
  logic [PH_W-1:0]   phase_next;
  logic [STEP_W-1:0] bend_step;
  logic signed [PROD_W-1:0] term_full;
  logic signed [ACC_W-1:0]  acc_sh, acc_off;
  logic [DAC_W-1:0]  dac_d;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign is_last    = (vidx_q == VI_W'(VOICE_COUNT - 1));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cur_active = voice_active_q[vidx_q];
  assign off_hit    = cur_active && (voice_note_q[vidx_q] == key_q);
  assign bend_hit   = cur_active && (voice_channel_q[vidx_q] == chan_q);

  // single wrap is a mask for a power-of-two table
  assign phase_sum  = SUM_W'(voice_phase_q[vidx_q]) + SUM_W'(voice_step_q[vidx_q]);
  assign phase_next = phase_sum[PH_W-1:0];

  assign bend_step = (|mul_prod_i[PROD_W-1:FRAC_W+STEP_W]) ? {STEP_W{1'b1}}
                                                           : mul_prod_i[FRAC_W+STEP_W-1:FRAC_W];
  assign term_full = mul_prod_i >>> TERM_SHIFT;

  assign acc_sh  = acc_q >>> ACC_SHIFT;
  assign acc_off = acc_sh + $signed(ACC_W'(DAC_MID));

  always_comb begin
    if (acc_off[ACC_W-1]) begin
      dac_d = '0;
    end else if (acc_off > $signed(ACC_W'(DAC_MAX))) begin
      dac_d = DAC_W'(DAC_MAX);
    end else begin
      dac_d = acc_off[DAC_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (func_i)
            FUNC_TICK:     state_d = ST_TICK_PH;
            FUNC_NOTE_ON:  state_d = (velocity_i == '0) ? ST_OFF_SCAN : ST_ON_SCAN;
            FUNC_NOTE_OFF: state_d = ST_OFF_SCAN;
            FUNC_BEND:     state_d = ST_BEND_SCAN;
            default:       state_d = ST_IDLE;
          endcase
        end
      end
      ST_TICK_PH: begin
        if (cur_active) begin
          state_d = ST_TICK_MUL;
        end else if (is_last) begin
          state_d = ST_TICK_OUT;
        end
      end
      ST_TICK_MUL:  state_d = ST_TICK_ACC;
      ST_TICK_ACC:  state_d = is_last ? ST_TICK_OUT : ST_TICK_PH;
      ST_TICK_OUT:  state_d = out_free ? ST_IDLE : ST_TICK_OUT;
      ST_ON_SCAN: begin
        if (!cur_active) begin
          state_d = ST_ON_LOAD;
        end else if (is_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_ON_LOAD:   state_d = ST_IDLE;
      ST_OFF_SCAN: begin
        if (off_hit) begin
          state_d = ST_OFF_LOAD;
        end else if (is_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_OFF_LOAD:  state_d = ST_IDLE;
      ST_BEND_SCAN: begin
        if (bend_hit) begin
          state_d = ST_BEND_MUL;
        end else if (is_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_BEND_MUL:  state_d = ST_BEND_WR;
      ST_BEND_WR:   state_d = is_last ? ST_IDLE : ST_BEND_SCAN;
      default:      state_d = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    vidx_inc = 1'b0;
    vw_stop  = accept && (func_i == FUNC_STOP);
    vw_phase = 1'b0;
    vw_on    = 1'b0;
    vw_off   = 1'b0;
    vw_bend  = 1'b0;
    out_load = 1'b0;
    acc_d    = acc_q;

    mem_req_o.wave_we    = accept && (func_i == FUNC_WAVE_WR) &&
                           (32'(wave_addr_i) < WAVE_DEPTH);
    mem_req_o.wave_waddr = wave_addr_i[WAVE_AW-1:0];
    mem_req_o.wave_wdata = wave_value_i;
    mem_req_o.wave_raddr = phase_next[PH_W-1:FRAC_W];
    mem_req_o.step_we    = accept && (func_i == FUNC_STEP_WR);
    mem_req_o.step_waddr = key_i;
    mem_req_o.step_wdata = step_value_i;
    mem_req_o.step_raddr = key_q;

    mul_req_o.a = $signed({1'b0, mem_rsp_i.step_rdata});
    mul_req_o.b = $signed({1'b0, mult_q});

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          acc_d = '0;
        end
      end
      ST_TICK_PH: begin
        vw_phase = cur_active;
        vidx_inc = !cur_active && !is_last;
      end
      ST_TICK_MUL: begin
        mul_req_o.a = MUL_A_W'(mem_rsp_i.wave_rdata);
        mul_req_o.b = $signed(MUL_B_W'(voice_volume_q[vidx_q]));
      end
      ST_TICK_ACC: begin
        acc_d    = acc_q + term_full[ACC_W-1:0];
        vidx_inc = !is_last;
      end
      ST_TICK_OUT: begin
        out_load = out_free;
      end
      ST_ON_SCAN: begin
        vidx_inc = cur_active && !is_last;
      end
      ST_ON_LOAD: begin
        vw_on = 1'b1;
      end
      ST_OFF_SCAN: begin
        vidx_inc = !off_hit && !is_last;
      end
      ST_OFF_LOAD: begin
        vw_off = 1'b1;
      end
      ST_BEND_SCAN: begin
        mem_req_o.step_raddr = voice_note_q[vidx_q];
        vidx_inc = !bend_hit && !is_last;
      end
      ST_BEND_MUL: begin
      end
      ST_BEND_WR: begin
        vw_bend  = 1'b1;
        vidx_inc = !is_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vidx_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      if (accept) begin
        vidx_q <= '0;
      end else if (vidx_inc) begin
        vidx_q <= vidx_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      chan_q <= channel_i;
      key_q  <= key_i;
      vel_q  <= velocity_i;
      mult_q <= BEND_MULT[bend_i[BEND_W-1:BEND_W-6]];
    end
    if (out_load) begin
      dac_q <= dac_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        voice_active_q[i]  <= 1'b0;
        voice_note_q[i]    <= '0;
        voice_channel_q[i] <= '0;
        voice_volume_q[i]  <= '0;
        voice_step_q[i]    <= '0;
        voice_phase_q[i]   <= '0;
      end
    end else if (vw_stop) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        voice_active_q[i]  <= 1'b0;
        voice_note_q[i]    <= '0;
        voice_channel_q[i] <= '0;
        voice_volume_q[i]  <= '0;
        voice_step_q[i]    <= '0;
        voice_phase_q[i]   <= '0;
      end
    end else begin
      if (vw_phase) begin
        voice_phase_q[vidx_q] <= phase_next;
      end
      if (vw_on) begin
        voice_active_q[vidx_q]  <= 1'b1;
        voice_note_q[vidx_q]    <= key_q;
        voice_channel_q[vidx_q] <= chan_q;
        voice_volume_q[vidx_q]  <= vel_q;
        voice_step_q[vidx_q]    <= mem_rsp_i.step_rdata;
        voice_phase_q[vidx_q]   <= '0;
      end
      if (vw_off) begin
        voice_active_q[vidx_q]  <= 1'b0;
        voice_channel_q[vidx_q] <= '0;
        voice_step_q[vidx_q]    <= mem_rsp_i.step_rdata;
      end
      if (vw_bend) begin
        voice_step_q[vidx_q] <= bend_step;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dac_sample_o = dac_q;

endmodule

`default_nettype wire

// ===== rtl/polyphonic_wavetable_voice_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// polyphonic_wavetable_voice_mixer_unit: 15-voice wavetable synthesiser
// Every beat is accepted in an idle cycle; wave write, step write, stop all
//   and the unused code leave the sequencer idle.
// Tick: each voice passes the phase and wave read state; an active voice also
//   passes the shared multiply and accumulate states. The output state then
//   loads the output register, held while the previous sample is stalled.
// Note on/off: a scan of the voices plus a load state on a find.
// Bend: a scan of the voices, and each matching voice passes the multiply
//   and write states through the multiplier. Reset clears voices at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module polyphonic_wavetable_voice_mixer_unit
  import pwvm_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [FUNC_W-1:0]        func_i,
  input  wire logic [CHAN_W-1:0]        channel_i,
  input  wire logic [KEY_W-1:0]         key_i,
  input  wire logic [VEL_W-1:0]         velocity_i,
  input  wire logic [BEND_W-1:0]        bend_i,
  input  wire logic [WADDR_W-1:0]       wave_addr_i,
  input  wire logic signed [WAVE_W-1:0] wave_value_i,
  input  wire logic [STEP_W-1:0]        step_value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [DAC_W-1:0]              dac_sample_o
);

  mem_req_t mem_req;
  mem_rsp_t mem_rsp;
  mul_req_t mul_req;
  logic signed [PROD_W-1:0] mul_prod;

  pwvm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .channel_i    (channel_i),
    .key_i        (key_i),
    .velocity_i   (velocity_i),
    .bend_i       (bend_i),
    .wave_addr_i  (wave_addr_i),
    .wave_value_i (wave_value_i),
    .step_value_i (step_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .dac_sample_o (dac_sample_o),
    .mem_req_o    (mem_req),
    .mem_rsp_i    (mem_rsp),
    .mul_req_o    (mul_req),
    .mul_prod_i   (mul_prod)
  );

  pwvm_mem u_mem (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rsp_o (mem_rsp)
  );

  pwvm_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_prod)
  );

endmodule

`default_nettype wire

// ===== rtl/pwvm_checker.sv =====
// ----------------------------------------------------------------------------
// pwvm_checker: port-level checks
// Output beat handshake and sequencing of the input side around ticks and memory writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwvm_checker
  import pwvm_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic [FUNC_W-1:0]  func_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [DAC_W-1:0]   dac_sample_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(dac_sample_o))
    else $error("output sample changed while stalled");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (func_i == FUNC_TICK) |=> in_stall_o)
    else $error("input not stalled after tick beat");

  a_out_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output beat without a tick in progress");

  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (func_i == FUNC_WAVE_WR || func_i == FUNC_STEP_WR)
    |=> !in_stall_o)
    else $error("memory write beat did not free the input");

endmodule

bind polyphonic_wavetable_voice_mixer_unit pwvm_checker u_pwvm_checker (.*);

`default_nettype wire
